// ===== rtl/core/pf_pkg.sv =====
package pf_pkg;

    localparam int SQUARE_SIDE = 5;
    localparam int CELLS       = SQUARE_SIDE * SQUARE_SIDE;
    localparam int LETTERS     = 26;

    typedef logic [4:0] t_letter;
    typedef logic [4:0] t_cell;
    typedef logic [2:0] t_coord;

    localparam t_letter LETTER_A = 5'd0;
    localparam t_letter LETTER_I = 5'd8;
    localparam t_letter LETTER_J = 5'd9;
    localparam t_letter LETTER_X = 5'd23;
    localparam t_letter LETTER_Z = 5'd25;

    localparam logic [1:0] MODE_KEY = 2'd0;
    localparam logic [1:0] MODE_ENC = 2'd1;
    localparam logic [1:0] MODE_DEC = 2'd2;

    typedef enum logic [1:0] {
        KIND_KEY,
        KIND_ENC,
        KIND_DEC
    } t_kind;

    typedef struct packed {
        t_kind   kind;
        t_letter first;
        t_letter second;
        logic    last;
    } t_cmd;

    typedef struct packed {
        logic not_empty;
        logic not_full;
    } t_queue_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_PLACE,
        ST_CELL
    } t_back_state;

    function automatic t_letter norm_letter(input t_letter v);
        t_letter c;
        c = (v > LETTER_Z) ? LETTER_Z : v;
        if (c == LETTER_J) begin
            c = LETTER_I;
        end
        return c;
    endfunction

    function automatic t_coord cell_row(input t_cell p);
        t_coord r;
        r = 3'd0;
        for (int k = 1; k < SQUARE_SIDE; k++) begin
            if (p >= t_cell'(k * SQUARE_SIDE)) begin
                r = t_coord'(k);
            end
        end
        return r;
    endfunction

    function automatic t_coord cell_col(input t_cell p);
        t_cell base;
        base = t_cell'(cell_row(p) * SQUARE_SIDE);
        return t_coord'(p - base);
    endfunction

    function automatic t_cell cell_at(input t_coord row, input t_coord col);
        return t_cell'(row * SQUARE_SIDE + col);
    endfunction

    function automatic t_coord coord_next(input t_coord c);
        return (c == t_coord'(SQUARE_SIDE - 1)) ? 3'd0 : c + 3'd1;
    endfunction

    function automatic t_coord coord_prev(input t_coord c);
        return (c == 3'd0) ? t_coord'(SQUARE_SIDE - 1) : c - 3'd1;
    endfunction

    function automatic t_letter reset_square(input t_cell p);
        return (p < LETTER_J) ? t_letter'(p) : t_letter'(p + 5'd1);
    endfunction

    function automatic t_cell reset_place(input t_letter c);
        return (c <= LETTER_I) ? t_cell'(c) : t_cell'(c - 5'd1);
    endfunction

endpackage

// ===== rtl/core/pf_front.sv =====
module pf_front
    import pf_pkg::*;
(
    input  logic          i_tvalid,
    output logic          o_tready,
    input  logic [15:0]   i_tdata,
    input  logic [1:0]    i_tuser,
    input  logic          i_tlast,
    input  t_queue_status i_queue,
    output logic          o_push,
    output t_cmd          o_cmd
);

    logic    w_keep;
    t_kind   w_kind;
    t_letter w_first;
    t_letter w_second;

    assign w_first  = norm_letter(i_tdata[4:0]);
    assign w_second = norm_letter(i_tdata[9:5]);

    always_comb begin
        w_keep = 1'b1;
        w_kind = KIND_KEY;
        case (i_tuser)
            MODE_KEY: w_kind = KIND_KEY;
            MODE_ENC: w_kind = KIND_ENC;
            MODE_DEC: w_kind = KIND_DEC;
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_cmd.kind   = w_kind;
        o_cmd.first  = w_first;
        o_cmd.second = (w_kind == KIND_ENC && !i_tdata[10]) ? LETTER_X : w_second;
        o_cmd.last   = i_tlast;
    end

    assign o_tready = i_queue.not_full;
    assign o_push   = i_tvalid && i_queue.not_full && w_keep;

endmodule

// ===== rtl/core/pf_queue.sv =====
module pf_queue
    import pf_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_cmd          i_cmd,
    input  logic          i_pop,
    output t_cmd          o_cmd,
    output t_queue_status o_status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic          w_push;
    logic          w_pop;

    assign w_push = i_push && (r_count != FULL);
    assign w_pop  = i_pop && (r_count != '0);

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_push) begin
            n_wr = (r_wr == LAST) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == LAST) ? '0 : r_rd + 1'b1;
        end
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    assign o_cmd              = r_mem[r_rd];
    assign o_status.not_empty = (r_count != '0);
    assign o_status.not_full  = (r_count != FULL);

endmodule

// ===== rtl/core/pf_back.sv =====
module pf_back
    import pf_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    input  t_queue_status i_queue,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output t_letter       o_out_first,
    output t_letter       o_out_second
);

    t_back_state        r_state, n_state;
    logic               r_loading, n_loading;
    logic [4:0]         r_fill, n_fill;
    logic [LETTERS-1:0] r_used, n_used;
    t_letter            r_scan, n_scan;
    logic               r_out_valid, n_out_valid;
    t_letter            r_out_first;
    t_letter            r_out_second;
    t_kind              r_kind;
    t_letter            r_a;
    t_letter            r_b;
    t_cell              r_cell_a;
    t_cell              r_cell_b;

    t_letter            mem_square [CELLS];
    t_cell              mem_place  [LETTERS];
    logic [CELLS-1:0]   r_sq_vld;
    logic [LETTERS-1:0] r_pl_vld;
    t_cell              r_pa_raw, r_pb_raw;
    logic               r_pa_vld, r_pb_vld;
    t_letter            r_oa_raw, r_ob_raw;
    logic               r_oa_vld, r_ob_vld;

    logic               w_out_free;
    logic               w_pop;
    logic               w_key;
    logic               w_pair;
    logic               w_load;
    logic               w_pl_try;
    t_letter            w_pl_letter;
    logic [LETTERS-1:0] w_used_base;
    logic [4:0]         w_fill_base;
    logic               w_wr;
    t_cell              w_pa, w_pb;
    t_coord             w_ra, w_ca, w_rb, w_cb;
    t_cell              w_cell_a, w_cell_b;
    t_letter            w_oa, w_ob;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_pop      = (r_state == ST_IDLE) && i_queue.not_empty;
    assign w_key      = w_pop && (i_cmd.kind == KIND_KEY);
    assign w_pair     = w_pop && (i_cmd.kind != KIND_KEY) && !r_loading;
    assign w_load     = (r_state == ST_CELL) && w_out_free;

    assign w_pl_letter = (r_state == ST_FILL) ? r_scan : i_cmd.first;
    assign w_pl_try    = w_key || ((r_state == ST_FILL) && (r_scan != LETTER_J));
    assign w_used_base = (w_key && !r_loading) ? '0 : r_used;
    assign w_fill_base = (w_key && !r_loading) ? '0 : r_fill;
    assign w_wr        = w_pl_try && !w_used_base[w_pl_letter] &&
                         (w_fill_base < 5'(CELLS));

    always_comb begin
        w_pa = r_pa_vld ? r_pa_raw : reset_place(r_a);
        w_pb = r_pb_vld ? r_pb_raw : reset_place(r_b);
        w_ra = cell_row(w_pa);
        w_ca = cell_col(w_pa);
        w_rb = cell_row(w_pb);
        w_cb = cell_col(w_pb);
        if (w_ra == w_rb) begin
            if (r_kind == KIND_ENC) begin
                w_cell_a = cell_at(w_ra, coord_next(w_ca));
                w_cell_b = cell_at(w_rb, coord_next(w_cb));
            end else begin
                w_cell_a = cell_at(w_ra, coord_prev(w_ca));
                w_cell_b = cell_at(w_rb, coord_prev(w_cb));
            end
        end else if (w_ca == w_cb) begin
            if (r_kind == KIND_ENC) begin
                w_cell_a = cell_at(coord_next(w_ra), w_ca);
                w_cell_b = cell_at(coord_next(w_rb), w_cb);
            end else begin
                w_cell_a = cell_at(coord_prev(w_ra), w_ca);
                w_cell_b = cell_at(coord_prev(w_rb), w_cb);
            end
        end else begin
            w_cell_a = cell_at(w_ra, w_cb);
            w_cell_b = cell_at(w_rb, w_ca);
        end
    end

    assign w_oa = r_oa_vld ? r_oa_raw : reset_square(r_cell_a);
    assign w_ob = r_ob_vld ? r_ob_raw : reset_square(r_cell_b);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_key && i_cmd.last) begin
                    n_state = ST_FILL;
                end else if (w_pair) begin
                    n_state = ST_PLACE;
                end
            end
            ST_FILL: begin
                if (r_scan == LETTER_Z) begin
                    n_state = ST_IDLE;
                end
            end
            ST_PLACE: n_state = ST_CELL;
            ST_CELL: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_loading   = r_loading;
        n_used      = w_used_base;
        n_fill      = w_fill_base + {4'd0, w_wr};
        n_scan      = r_scan;
        n_out_valid = r_out_valid;
        if (w_wr) begin
            n_used[w_pl_letter] = 1'b1;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_key) begin
                    n_loading = 1'b1;
                    n_scan    = LETTER_A;
                end
            end
            ST_FILL: begin
                n_scan = r_scan + 5'd1;
                if (r_scan == LETTER_Z) begin
                    n_loading = 1'b0;
                end
            end
            default: begin
                n_scan = r_scan;
            end
        endcase
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_loading   <= 1'b0;
            r_fill      <= '0;
            r_used      <= '0;
            r_scan      <= LETTER_A;
            r_out_valid <= 1'b0;
            r_sq_vld    <= '0;
            r_pl_vld    <= '0;
        end else begin
            r_state     <= n_state;
            r_loading   <= n_loading;
            r_fill      <= n_fill;
            r_used      <= n_used;
            r_scan      <= n_scan;
            r_out_valid <= n_out_valid;
            if (w_wr) begin
                r_sq_vld[w_fill_base] <= 1'b1;
                r_pl_vld[w_pl_letter] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            mem_square[w_fill_base] <= w_pl_letter;
            mem_place[w_pl_letter]  <= w_fill_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pair) begin
            r_kind   <= i_cmd.kind;
            r_a      <= i_cmd.first;
            r_b      <= i_cmd.second;
            r_pa_raw <= mem_place[i_cmd.first];
            r_pb_raw <= mem_place[i_cmd.second];
            r_pa_vld <= r_pl_vld[i_cmd.first];
            r_pb_vld <= r_pl_vld[i_cmd.second];
        end
        if (r_state == ST_PLACE) begin
            r_cell_a <= w_cell_a;
            r_cell_b <= w_cell_b;
            r_oa_raw <= mem_square[w_cell_a];
            r_ob_raw <= mem_square[w_cell_b];
            r_oa_vld <= r_sq_vld[w_cell_a];
            r_ob_vld <= r_sq_vld[w_cell_b];
        end
        if (w_load) begin
            r_out_first  <= w_oa;
            r_out_second <= w_ob;
        end
    end

    assign o_pop        = w_pop;
    assign o_out_valid  = r_out_valid;
    assign o_out_first  = r_out_first;
    assign o_out_second = r_out_second;

endmodule

// ===== rtl/core/playfair_digraph_cipher.sv =====
// Channel  Direction  Signals                          Payload
// s_axis   in         tvalid tready tdata tuser tlast  letters, mode, end of keyword
// m_axis   out        tvalid tready tdata              transformed pair
//
// A pair passes through the execution unit in order: a registered read of the
// letter positions, a registered read of the two target cells, and the load
// of the output register once it is free. Each keyword letter is handled as
// it is popped; the last one adds a walk over the alphabet through the single
// square write port. Reset is synchronous; no clearing pass is needed.
// The command queue lets the input side keep accepting while a result waits.
module playfair_digraph_cipher
    import pf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Bits from the lowest: first_letter[4:0], second_letter[9:5],
    // second_present[10], zero fill[15:11].
    input  logic [15:0] s_axis_tdata,
    // Bits from the lowest: mode[1:0].
    input  logic [1:0]  s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Bits from the lowest: out_first[4:0], out_second[9:5], zero fill[15:10].
    output logic [15:0] m_axis_tdata
);

    t_queue_status w_status;
    logic          w_push;
    logic          w_pop;
    t_cmd          w_front_cmd;
    t_cmd          w_back_cmd;
    t_letter       w_out_first;
    t_letter       w_out_second;

    pf_front u_front (
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .i_tlast  (s_axis_tlast),
        .i_queue  (w_status),
        .o_push   (w_push),
        .o_cmd    (w_front_cmd)
    );

    pf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_front_cmd),
        .i_pop    (w_pop),
        .o_cmd    (w_back_cmd),
        .o_status (w_status)
    );

    pf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_back_cmd),
        .i_queue      (w_status),
        .o_pop        (w_pop),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_first  (w_out_first),
        .o_out_second (w_out_second)
    );

    assign m_axis_tdata = {6'd0, w_out_second, w_out_first};

endmodule
